>>> rtl/sale_pkg.sv
// shared constants, codes and controller/datapath command types for the list engine
package sale_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned DW     = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CMP_W  = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEDUP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP    = 3'd4;

  localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STATUS_BAD       = 2'd1;
  localparam logic [STS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    RA_I,
    RA_I_M1,
    RA_J,
    RA_MIRROR
  } sale_ra_e;

  typedef enum logic [1:0] {
    WA_I,
    WA_W,
    WA_MIRROR,
    WA_POS
  } sale_wa_e;

  typedef enum logic [1:0] {
    WD_RDATA,
    WD_VALUE,
    WD_CUR,
    WD_TMP
  } sale_wd_e;

  typedef enum logic [1:0] {
    I_HOLD,
    I_INC,
    I_DEC
  } sale_iop_e;

  typedef struct packed {
    logic      load;
    logic      re;
    sale_ra_e  ra_sel;
    logic      we;
    sale_wa_e  wa_sel;
    sale_wd_e  wd_sel;
    sale_iop_e i_op;
    logic      w_inc;
    logic      j_clr;
    logic      j_inc;
    logic      cur_ld;
    logic      tmp_ld;
    logic      seen_clr;
    logic      seen_set;
    logic      finish;
    logic      dump_out;
  } sale_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              i_ge_pos;
    logic              i_lt_total;
    logic              i_lt_half;
    logic              j_lt_w;
    logic              total_zero;
    logic              dump_last;
    logic              match_val;
    logic              seen;
    logic              out_free;
  } sale_sts_t;

endpackage

>>> rtl/sale_in_if.sv
// command channel: valid/ready handshake with the command fields
interface sale_in_if import sale_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DW-1:0]     value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

>>> rtl/sale_out_if.sv
// result channel: valid/ready handshake with the result fields
interface sale_out_if import sale_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STS_W-1:0]     status;
  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     removed;
  logic                 has_element;
  logic signed [DW-1:0] element;
  logic [IDX_W-1:0]     element_index;
  logic                 last;

  modport source (output valid, output status, output entry_count, output removed,
                  output has_element, output element, output element_index, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input removed,
                  input has_element, input element, input element_index, input last,
                  output ready);
endinterface

>>> rtl/sale_ram.sv
// generic single-write, single-read ram with registered read data
module sale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sale_dp.sv
// datapath: list store, counters, compare logic and the result register
module sale_dp import sale_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KIND_W-1:0]    in_kind_i,
  input  logic [DW-1:0]        in_value_i,
  input  logic [POS_W-1:0]     in_position_i,
  input  sale_cmd_t            cmd_i,
  output sale_sts_t            sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STS_W-1:0]     out_status_o,
  output logic [CNT_W-1:0]     out_entry_count_o,
  output logic [CNT_W-1:0]     out_removed_o,
  output logic                 out_has_element_o,
  output logic [DW-1:0]        out_element_o,
  output logic [IDX_W-1:0]     out_element_index_o,
  output logic                 out_last_o
);

  logic [KIND_W-1:0] kind_q;
  logic [DW-1:0]     val_q;
  logic [CW-1:0]     pos_q;
  logic              bad_q;
  logic [CW-1:0]     total_q, total_d;
  logic [CW-1:0]     i_q, j_q, w_q;
  logic [DW-1:0]     cur_q, tmp_q;
  logic              seen_q;

  logic              out_valid_q;
  logic [STS_W-1:0]  out_status_q;
  logic [CNT_W-1:0]  out_count_q, out_removed_q;
  logic              out_has_q, out_last_q;
  logic [DW-1:0]     out_elem_q;
  logic [IDX_W-1:0]  out_idx_q;

  logic [AW-1:0]     raddr, waddr;
  logic [DW-1:0]     wdata, rdata;
  logic [CW-1:0]     i_m1, pos_m1, mirror;
  logic              ins_ok, kind_ok, load_bad;
  logic [CW-1:0]     rem;
  logic              out_free;

  sale_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign i_m1   = i_q - 1'b1;
  assign pos_m1 = pos_q - 1'b1;
  assign mirror = total_q - 1'b1 - i_q;
  assign rem    = total_q - w_q;

  always_comb begin
    case (cmd_i.ra_sel)
      RA_I:      raddr = i_q[AW-1:0];
      RA_I_M1:   raddr = i_m1[AW-1:0];
      RA_J:      raddr = j_q[AW-1:0];
      RA_MIRROR: raddr = mirror[AW-1:0];
      default:   raddr = i_q[AW-1:0];
    endcase
    case (cmd_i.wa_sel)
      WA_I:      waddr = i_q[AW-1:0];
      WA_W:      waddr = w_q[AW-1:0];
      WA_MIRROR: waddr = mirror[AW-1:0];
      WA_POS:    waddr = pos_m1[AW-1:0];
      default:   waddr = i_q[AW-1:0];
    endcase
    case (cmd_i.wd_sel)
      WD_RDATA: wdata = rdata;
      WD_VALUE: wdata = val_q;
      WD_CUR:   wdata = cur_q;
      WD_TMP:   wdata = tmp_q;
      default:  wdata = rdata;
    endcase
  end

  // insert is legal for positions 1 .. count+1 while there is room
  assign ins_ok = (total_q < CW'(DEPTH)) && (in_position_i != '0) &&
                  (CMP_W'(in_position_i) <= CMP_W'(total_q) + CMP_W'(1));
  assign kind_ok  = in_kind_i inside {[KIND_INSERT:KIND_DUMP]};
  assign load_bad = !kind_ok || ((in_kind_i == KIND_INSERT) && !ins_ok);

  always_comb begin
    total_d = total_q;
    if (cmd_i.finish && !bad_q) begin
      case (kind_q)
        KIND_INSERT: total_d = total_q + 1'b1;
        KIND_DELETE,
        KIND_DEDUP:  total_d = w_q;
        default:     total_d = total_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (cmd_i.finish || cmd_i.dump_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      val_q  <= in_value_i;
      pos_q  <= CW'(in_position_i);
      bad_q  <= load_bad;
      w_q    <= '0;
      i_q    <= (in_kind_i == KIND_INSERT) ? total_q : '0;
    end else begin
      case (cmd_i.i_op)
        I_INC:   i_q <= i_q + 1'b1;
        I_DEC:   i_q <= i_q - 1'b1;
        default: i_q <= i_q;
      endcase
      if (cmd_i.w_inc) begin
        w_q <= w_q + 1'b1;
      end
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.seen_clr) begin
      seen_q <= 1'b0;
    end else if (cmd_i.seen_set && (rdata == cur_q)) begin
      seen_q <= 1'b1;
    end
    if (cmd_i.cur_ld) begin
      cur_q <= rdata;
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rdata;
    end
    if (cmd_i.finish) begin
      out_has_q     <= 1'b0;
      out_elem_q    <= '0;
      out_idx_q     <= '0;
      out_last_q    <= 1'b1;
      out_count_q   <= CNT_W'(total_d);
      out_removed_q <= '0;
      out_status_q  <= STATUS_OK;
      if (bad_q) begin
        out_status_q <= STATUS_BAD;
      end else if (kind_q == KIND_DELETE) begin
        out_removed_q <= CNT_W'(rem);
        out_status_q  <= (rem == '0) ? STATUS_NOT_FOUND : STATUS_OK;
      end else if (kind_q == KIND_DEDUP) begin
        out_removed_q <= CNT_W'(rem);
      end
    end else if (cmd_i.dump_out) begin
      out_has_q     <= 1'b1;
      out_elem_q    <= rdata;
      out_idx_q     <= IDX_W'(i_q);
      out_last_q    <= (i_q + 1'b1 == total_q);
      out_count_q   <= CNT_W'(total_q);
      out_removed_q <= '0;
      out_status_q  <= STATUS_OK;
    end
  end

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.bad        = bad_q;
    sts_o.i_ge_pos   = (i_q >= pos_q);
    sts_o.i_lt_total = (i_q < total_q);
    sts_o.i_lt_half  = (i_q < (total_q >> 1));
    sts_o.j_lt_w     = (j_q < w_q);
    sts_o.total_zero = (total_q == '0);
    sts_o.dump_last  = (i_q + 1'b1 == total_q);
    sts_o.match_val  = (rdata == val_q);
    sts_o.seen       = seen_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_entry_count_o   = out_count_q;
  assign out_removed_o       = out_removed_q;
  assign out_has_element_o   = out_has_q;
  assign out_element_o       = out_elem_q;
  assign out_element_index_o = out_idx_q;
  assign out_last_o          = out_last_q;

endmodule

>>> rtl/sale_ctrl.sv
// controller state machine: sequences reads, writes and results for each command
module sale_ctrl import sale_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sale_sts_t sts_i,
  output sale_cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_EMIT   = 5'd2;
  localparam logic [4:0] S_INS_RD = 5'd3;
  localparam logic [4:0] S_INS_WR = 5'd4;
  localparam logic [4:0] S_INS_PUT = 5'd5;
  localparam logic [4:0] S_DEL_RD = 5'd6;
  localparam logic [4:0] S_DEL_WR = 5'd7;
  localparam logic [4:0] S_DD_RD  = 5'd8;
  localparam logic [4:0] S_DD_CUR = 5'd9;
  localparam logic [4:0] S_DD_SCAN = 5'd10;
  localparam logic [4:0] S_DD_CMP = 5'd11;
  localparam logic [4:0] S_DD_PUT = 5'd12;
  localparam logic [4:0] S_RV_RD  = 5'd13;
  localparam logic [4:0] S_RV_RD2 = 5'd14;
  localparam logic [4:0] S_RV_W1  = 5'd15;
  localparam logic [4:0] S_RV_W2  = 5'd16;
  localparam logic [4:0] S_DP_RD  = 5'd17;
  localparam logic [4:0] S_DP_OUT = 5'd18;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ra_sel = RA_I;
    cmd_o.wa_sel = WA_I;
    cmd_o.wd_sel = WD_RDATA;
    cmd_o.i_op   = I_HOLD;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.bad) begin
          state_d = S_EMIT;
        end else begin
          case (sts_i.kind)
            KIND_INSERT:  state_d = S_INS_RD;
            KIND_DELETE:  state_d = S_DEL_RD;
            KIND_DEDUP:   state_d = S_DD_RD;
            KIND_REVERSE: state_d = S_RV_RD;
            KIND_DUMP:    state_d = sts_i.total_zero ? S_EMIT : S_DP_RD;
            default:      state_d = S_EMIT;
          endcase
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      // insert: move entries up from the top down to the insert slot
      S_INS_RD: begin
        if (sts_i.i_ge_pos) begin
          cmd_o.re     = 1'b1;
          cmd_o.ra_sel = RA_I_M1;
          state_d      = S_INS_WR;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.i_op = I_DEC;
        state_d    = S_INS_RD;
      end
      S_INS_PUT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wa_sel = WA_POS;
        cmd_o.wd_sel = WD_VALUE;
        state_d      = S_EMIT;
      end
      // delete: compact the list, dropping matches
      S_DEL_RD: begin
        if (sts_i.i_lt_total) begin
          cmd_o.re = 1'b1;
          state_d  = S_DEL_WR;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DEL_WR: begin
        if (!sts_i.match_val) begin
          cmd_o.we     = 1'b1;
          cmd_o.wa_sel = WA_W;
          cmd_o.w_inc  = 1'b1;
        end
        cmd_o.i_op = I_INC;
        state_d    = S_DEL_RD;
      end
      // dedup: scan the kept prefix for each entry
      S_DD_RD: begin
        if (sts_i.i_lt_total) begin
          cmd_o.re       = 1'b1;
          cmd_o.j_clr    = 1'b1;
          cmd_o.seen_clr = 1'b1;
          state_d        = S_DD_CUR;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DD_CUR: begin
        cmd_o.cur_ld = 1'b1;
        state_d      = S_DD_SCAN;
      end
      S_DD_SCAN: begin
        if (sts_i.j_lt_w && !sts_i.seen) begin
          cmd_o.re     = 1'b1;
          cmd_o.ra_sel = RA_J;
          cmd_o.j_inc  = 1'b1;
          state_d      = S_DD_CMP;
        end else begin
          state_d = S_DD_PUT;
        end
      end
      S_DD_CMP: begin
        cmd_o.seen_set = 1'b1;
        state_d        = S_DD_SCAN;
      end
      S_DD_PUT: begin
        if (!sts_i.seen) begin
          cmd_o.we     = 1'b1;
          cmd_o.wa_sel = WA_W;
          cmd_o.wd_sel = WD_CUR;
          cmd_o.w_inc  = 1'b1;
        end
        cmd_o.i_op = I_INC;
        state_d    = S_DD_RD;
      end
      // reverse: swap pairs over the first half
      S_RV_RD: begin
        if (sts_i.i_lt_half) begin
          cmd_o.re = 1'b1;
          state_d  = S_RV_RD2;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_RV_RD2: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.re     = 1'b1;
        cmd_o.ra_sel = RA_MIRROR;
        state_d      = S_RV_W1;
      end
      S_RV_W1: begin
        cmd_o.we = 1'b1;
        state_d  = S_RV_W2;
      end
      S_RV_W2: begin
        cmd_o.we     = 1'b1;
        cmd_o.wa_sel = WA_MIRROR;
        cmd_o.wd_sel = WD_TMP;
        cmd_o.i_op   = I_INC;
        state_d      = S_RV_RD;
      end
      S_DP_RD: begin
        cmd_o.re = 1'b1;
        state_d  = S_DP_OUT;
      end
      S_DP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.dump_out = 1'b1;
          cmd_o.i_op     = I_INC;
          state_d        = sts_i.dump_last ? S_IDLE : S_DP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/small_array_list_engine.sv
// list engine: one command at a time; after dispatch, insert moves entries above the slot up
// and writes the value, delete reads each entry and keeps those that do not match, reverse
// reads and writes both ends of each swap, dedup compares each entry with the kept prefix,
// then emit; dump reads and sends each entry in turn; all steps share one ram port
// throughput: the next command is taken once the last result is queued; a held result stalls
// reset: asynchronous active low, empties the list; store contents are not cleared
module small_array_list_engine import sale_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sale_in_if.sink       in_i,
  sale_out_if.source    out_o
);

  sale_cmd_t cmd;
  sale_sts_t sts;

  sale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sale_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_kind_i           (in_i.kind),
    .in_value_i          (in_i.value),
    .in_position_i       (in_i.position),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .out_status_o        (out_o.status),
    .out_entry_count_o   (out_o.entry_count),
    .out_removed_o       (out_o.removed),
    .out_has_element_o   (out_o.has_element),
    .out_element_o       (out_o.element),
    .out_element_index_o (out_o.element_index),
    .out_last_o          (out_o.last)
  );

endmodule

>>> rtl/sale_checker.sv
// port-level checks for the list engine, bound to the top level
module sale_checker import sale_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [STS_W-1:0] out_status_i,
  input logic [CNT_W-1:0] out_removed_i,
  input logic             out_has_element_i,
  input logic             out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("stalled result dropped or changed");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while another is in flight");

  // a dump run that is not finished keeps the command port closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_has_element_i && !out_last_i |-> !in_ready_i)
    else $error("command taken in the middle of a dump");

  // not found goes with nothing removed and ends the command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_NOT_FOUND) |->
      (out_removed_i == '0) && out_last_i && !out_has_element_i)
    else $error("inconsistent not found result");

endmodule

bind small_array_list_engine sale_checker u_sale_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_removed_i     (out_o.removed),
  .out_has_element_i (out_o.has_element),
  .out_last_i        (out_o.last)
);
